// File: sv/sst_pkg.sv
// Shared types and constants for the sortable stack.
// Used by sst_cell and sortable_stack; depends on nothing.
`timescale 1ns / 1ps

package sst_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int COUNT_W         = 5;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_PEEK = 2'd2,
      FUNC_SORT = 2'd3
   } sst_func_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } sst_err_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2,
      CELL_SORT = 2'd3
   } sst_cell_op_type;

   typedef enum logic {
      ST_READY = 1'b0,
      ST_SORT  = 1'b1
   } sst_state_type;

   typedef struct packed {
      sst_func_type             func;
      logic signed [DATA_W-1:0] push_value;
   } sst_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      sst_err_type              error_code;
      logic                     is_empty;
      logic                     is_full;
      logic [COUNT_W-1:0]       entry_count;
   } sst_rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      sst_cell_op_type    op;
      logic               phase;
      logic [COUNT_W-1:0] count;
   } sst_cell_ctrl_type;

endpackage

// File: sv/sortable_stack.sv
// Top level of the sortable stack: request/response handshake, control and the cell row.
// Depends on sst_pkg and sst_cell.
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit words held in a row of STACK_DEPTH cells, top of
// stack in cell 0. Push, pop and peek take one request per cycle; the response is
// registered and a new request is taken while the previous response waits, as long
// as rsp_ready frees the output register. Sort answers at once and then runs one
// odd-even transposition pass per cycle across the cell row, count passes in all
// (none for zero or one entry), during which req_ready stays low; afterwards the
// values ascend from bottom to top. Capacity is csr_write_data, zero read as one and
// values above STACK_DEPTH clamped to it; a push at or above capacity is refused
// with overflow, a pop or peek of an empty stack reports underflow.
module sortable_stack #(
   parameter int STACK_DEPTH = sst_pkg::STACK_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sst_pkg::sst_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sst_pkg::sst_rsp_type         rsp_data,
   input  logic                         csr_write_enable,
   input  logic [sst_pkg::COUNT_W-1:0]  csr_write_data
);

   logic [sst_pkg::COUNT_W-1:0] capacity_ff;
   logic [sst_pkg::COUNT_W-1:0] count_ff;
   logic [sst_pkg::COUNT_W-1:0] count_in;
   logic [sst_pkg::COUNT_W-1:0] pass_ff;
   logic [sst_pkg::COUNT_W-1:0] pass_in;
   logic [sst_pkg::COUNT_W-1:0] eff_capacity;
   sst_pkg::sst_state_type      state_ff;
   sst_pkg::sst_state_type      state_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   sst_pkg::sst_rsp_type        rsp_ff;
   sst_pkg::sst_rsp_type        rsp_in;
   sst_pkg::sst_cell_ctrl_type  cell_ctrl;
   logic                        req_accept;
   logic                        stack_full;
   logic                        stack_empty;
   logic                        sort_last_pass;

   logic signed [sst_pkg::DATA_W-1:0] cell_value [STACK_DEPTH];

   assign req_accept     = req_valid && req_ready;
   assign stack_full     = (count_ff >= eff_capacity);
   assign stack_empty    = (count_ff == '0);
   assign sort_last_pass = (pass_ff == count_ff - 5'd1);

   always_comb begin
      if (capacity_ff == '0) begin
         eff_capacity = 5'd1;
      end else if (int'(capacity_ff) > STACK_DEPTH) begin
         eff_capacity = 5'(STACK_DEPTH);
      end else begin
         eff_capacity = capacity_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sst_pkg::ST_READY: begin
            if (req_accept && (req_data.func == sst_pkg::FUNC_SORT)
                && (count_ff >= 5'd2)) begin
               state_in = sst_pkg::ST_SORT;
            end
         end
         sst_pkg::ST_SORT: begin
            if (sort_last_pass) begin
               state_in = sst_pkg::ST_READY;
            end
         end
         default: state_in = sst_pkg::ST_READY;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready       = 1'b0;
      cell_ctrl.op    = sst_pkg::CELL_HOLD;
      cell_ctrl.phase = pass_ff[0];
      cell_ctrl.count = count_ff;
      case (state_ff)
         sst_pkg::ST_READY: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_accept) begin
               case (req_data.func)
                  sst_pkg::FUNC_PUSH: begin
                     if (!stack_full) begin
                        cell_ctrl.op = sst_pkg::CELL_PUSH;
                     end
                  end
                  sst_pkg::FUNC_POP: begin
                     if (!stack_empty) begin
                        cell_ctrl.op = sst_pkg::CELL_POP;
                     end
                  end
                  default: cell_ctrl.op = sst_pkg::CELL_HOLD;
               endcase
            end
         end
         sst_pkg::ST_SORT: cell_ctrl.op = sst_pkg::CELL_SORT;
         default: cell_ctrl.op = sst_pkg::CELL_HOLD;
      endcase
   end

   always_comb begin
      pass_in = pass_ff;
      if (state_ff == sst_pkg::ST_SORT) begin
         pass_in = pass_ff + 5'd1;
      end else begin
         pass_in = '0;
      end
   end

   // count and response
   always_comb begin
      count_in           = count_ff;
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         rsp_valid_in      = 1'b1;
         rsp_in.read_value = '0;
         rsp_in.error_code = sst_pkg::ERR_NONE;
         case (req_data.func)
            sst_pkg::FUNC_PUSH: begin
               if (stack_full) begin
                  rsp_in.error_code = sst_pkg::ERR_OVERFLOW;
               end else begin
                  count_in = count_ff + 5'd1;
               end
            end
            sst_pkg::FUNC_POP, sst_pkg::FUNC_PEEK: begin
               if (stack_empty) begin
                  rsp_in.error_code = sst_pkg::ERR_UNDERFLOW;
               end else begin
                  rsp_in.read_value = cell_value[0];
                  if (req_data.func == sst_pkg::FUNC_POP) begin
                     count_in = count_ff - 5'd1;
                  end
               end
            end
            default: count_in = count_ff;
         endcase
         rsp_in.entry_count = count_in;
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.is_full     = (count_in >= eff_capacity);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= sst_pkg::CAPACITY_RESET;
         count_ff     <= '0;
         pass_ff      <= '0;
         state_ff     <= sst_pkg::ST_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         pass_ff      <= pass_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // cell row: cell 0 is the top of stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic signed [sst_pkg::DATA_W-1:0] above_value;
      logic signed [sst_pkg::DATA_W-1:0] below_value;

      if (i == 0) begin : g_top
         assign above_value = req_data.push_value;
      end else begin : g_mid_above
         assign above_value = cell_value[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below_value = cell_value[i];
      end else begin : g_mid_below
         assign below_value = cell_value[i+1];
      end

      sst_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .above_value (above_value),
         .below_value (below_value),
         .value       (cell_value[i])
      );
   end

   // no request is taken while a sort runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::ST_SORT) |-> !req_ready)
      else $error("request accepted during sort");

   assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= STACK_DEPTH)
      else $error("entry count beyond built depth");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.func == sst_pkg::FUNC_PUSH) && !stack_full)
      |=> (count_ff == 5'($past(count_ff) + 5'd1)))
      else $error("push did not grow the stack");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::ST_SORT) |-> (count_ff >= 5'd2) && $stable(count_ff))
      else $error("sort running on a short or changing stack");

endmodule

// File: sv/sst_cell.sv
// One stack entry of the cell row: shifts on push/pop and does one
// compare-exchange step per sort pass. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  sst_pkg::sst_cell_ctrl_type        ctrl,
   input  logic signed [sst_pkg::DATA_W-1:0] above_value,
   input  logic signed [sst_pkg::DATA_W-1:0] below_value,
   output logic signed [sst_pkg::DATA_W-1:0] value
);

   localparam logic ODD_CELL  = 1'(CELL_INDEX % 2);
   localparam logic HAS_ABOVE = (CELL_INDEX > 0);

   logic signed [sst_pkg::DATA_W-1:0] value_ff;
   logic signed [sst_pkg::DATA_W-1:0] value_in;
   logic                              upper_role;
   logic                              lower_role;

   // pair (i, i+1) is active on passes whose parity matches i; top of pair keeps the max
   assign upper_role = (ODD_CELL == ctrl.phase) && (CELL_INDEX + 1 < int'(ctrl.count));
   assign lower_role = HAS_ABOVE && (ODD_CELL != ctrl.phase)
                       && (CELL_INDEX < int'(ctrl.count));

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         sst_pkg::CELL_HOLD: value_in = value_ff;
         sst_pkg::CELL_PUSH: value_in = above_value;
         sst_pkg::CELL_POP:  value_in = below_value;
         sst_pkg::CELL_SORT: begin
            if (upper_role && (value_ff < below_value)) begin
               value_in = below_value;
            end else if (lower_role && (above_value < value_ff)) begin
               value_in = above_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
